### rtl/core/aed_pkg.sv
// aed_pkg: shared types, widths, register codes and reset values for the
// audio event detector. No dependencies; every rtl/core file refers to it.
package aed_pkg;

  // Sample width; the payload struct below takes it from here.
  localparam int SAMPLE_BITS    = 16;
  localparam int CFG_BITS       = 16;
  localparam int LEVEL_OUT_BITS = 16;
  localparam int PHASE_BITS     = 2;
  localparam int COUNT_BITS_DEF = 16;

  // Envelope: sample scale with 16 fraction bits below it. It peaks at
  // 2^(SAMPLE_BITS-1+16), so it needs SAMPLE_BITS+16 bits.
  localparam int ENV_FRAC_BITS = 16;
  localparam int ENV_BITS      = SAMPLE_BITS + ENV_FRAC_BITS;
  localparam int FACTOR_BITS   = 16;
  localparam int PROD_BITS     = ENV_BITS + FACTOR_BITS;

  // Common width for the level-versus-threshold compare.
  localparam int LVL_CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_AMP_THRESHOLD    = 2'd0,
    CFG_RESPONSE_FACTOR  = 2'd1,
    CFG_TRAILING_SILENCE = 2'd2,
    CFG_MIN_EVENT        = 2'd3
  } cfg_index_t;

  localparam logic [CFG_BITS-1:0] AMP_THRESHOLD_RST    = 16'd33;
  localparam logic [CFG_BITS-1:0] RESPONSE_FACTOR_RST  = 16'd15;
  localparam logic [CFG_BITS-1:0] TRAILING_SILENCE_RST = 16'd86;
  localparam logic [CFG_BITS-1:0] MIN_EVENT_RST        = 16'd0;

  // Reported phase codes.
  localparam logic [PHASE_BITS-1:0] PHASE_WAITING  = 2'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_SOUNDING = 2'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_TRAILING = 2'd2;

  // Detector state, one-hot.
  typedef enum logic [2:0] {
    ST_WAITING  = 3'b001,
    ST_SOUNDING = 3'b010,
    ST_TRAILING = 3'b100
  } det_state_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] amp_threshold;
    logic [CFG_BITS-1:0] response_factor;
    logic [CFG_BITS-1:0] trailing_silence_buffers;
    logic [CFG_BITS-1:0] min_event_buffers;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          buffer_end;
  } src_item_t;

  typedef struct packed {
    logic                      event_start;
    logic                      event_end;
    logic [LEVEL_OUT_BITS-1:0] level;
    logic [PHASE_BITS-1:0]     phase;
  } res_item_t;

endpackage

### rtl/core/aed_smoother.sv
// aed_smoother: one-pole envelope of |sample|, one update per enabled cycle.
// Depends on aed_pkg.
module aed_smoother (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic signed [aed_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [aed_pkg::FACTOR_BITS-1:0]     response_factor,
  output logic [aed_pkg::SAMPLE_BITS-1:0]     level_next
);

  localparam int SB = aed_pkg::SAMPLE_BITS;
  localparam int EB = aed_pkg::ENV_BITS;
  localparam int PB = aed_pkg::PROD_BITS;
  localparam int FB = aed_pkg::ENV_FRAC_BITS;

  logic [EB-1:0] envelope;
  logic [EB-1:0] envelope_next;
  logic [SB-1:0] sample_u;
  logic [SB-1:0] mag;
  logic [EB-1:0] target;
  logic          rising;
  logic [EB-1:0] diff;
  logic [PB-1:0] prod;
  logic [PB-1:0] prod_rnd;
  logic [EB-1:0] step;

  // Two's complement negate; the most negative code maps to 2^(SB-1) unsigned.
  assign sample_u = sample;
  assign mag      = sample_u[SB-1] ? (~sample_u + SB'(1)) : sample_u;
  assign target   = {mag, {FB{1'b0}}};
  assign rising   = (target >= envelope);
  assign diff     = rising ? (target - envelope) : (envelope - target);
  assign prod     = PB'(response_factor) * PB'(diff);
  // Falling step rounds up in magnitude: floor toward minus infinity overall.
  assign prod_rnd = rising ? prod : (prod + PB'({FB{1'b1}}));
  assign step     = prod_rnd[PB-1:FB];

  assign envelope_next = rising ? (envelope + step) : (envelope - step);
  assign level_next    = envelope_next[EB-1:FB];

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= '0;
    end else if (en) begin
      envelope <= envelope_next;
    end
  end

endmodule

### rtl/core/aed_detector.sv
// aed_detector: waiting / sounding / trailing-silence state machine with
// saturating event and silence counters. Depends on aed_pkg.
module aed_detector #(
  parameter int COUNT_BITS = aed_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [aed_pkg::SAMPLE_BITS-1:0] level,
  input  aed_pkg::cfg_t                   cfg,
  output aed_pkg::res_item_t              result
);

  localparam int CMP_BITS = (COUNT_BITS > aed_pkg::CFG_BITS) ? COUNT_BITS : aed_pkg::CFG_BITS;
  localparam int LCB      = aed_pkg::LVL_CMP_BITS;

  aed_pkg::det_state_t state;
  aed_pkg::det_state_t state_next;
  logic [COUNT_BITS-1:0] event_length;
  logic [COUNT_BITS-1:0] event_length_next;
  logic [COUNT_BITS-1:0] silence_length;
  logic [COUNT_BITS-1:0] silence_length_next;

  logic                  above;
  logic                  below;
  logic [COUNT_BITS-1:0] ev_inc;
  logic [COUNT_BITS-1:0] sil_inc;
  logic [CMP_BITS-1:0]   ev_ext;
  logic [CMP_BITS-1:0]   sil_ext;
  logic [CMP_BITS-1:0]   trail_ext;
  logic [CMP_BITS-1:0]   min_ext;
  logic [CMP_BITS-1:0]   ev_trim;
  logic                  start_flag;
  logic                  end_flag;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : (v + COUNT_BITS'(1));
  endfunction

  function automatic logic [aed_pkg::PHASE_BITS-1:0] phase_code(input aed_pkg::det_state_t s);
    logic [aed_pkg::PHASE_BITS-1:0] code;
    unique case (s)
      aed_pkg::ST_SOUNDING: code = aed_pkg::PHASE_SOUNDING;
      aed_pkg::ST_TRAILING: code = aed_pkg::PHASE_TRAILING;
      default:              code = aed_pkg::PHASE_WAITING;
    endcase
    return code;
  endfunction

  assign above = LCB'(level) > LCB'(cfg.amp_threshold);
  assign below = LCB'(level) < LCB'(cfg.amp_threshold);

  assign ev_inc    = sat_inc(event_length);
  assign sil_inc   = sat_inc(silence_length);
  assign ev_ext    = CMP_BITS'(ev_inc);
  assign sil_ext   = CMP_BITS'(sil_inc);
  assign trail_ext = CMP_BITS'(cfg.trailing_silence_buffers);
  assign min_ext   = CMP_BITS'(cfg.min_event_buffers);
  assign ev_trim   = (ev_ext >= trail_ext) ? (ev_ext - trail_ext) : '0;

  always_comb begin
    state_next          = state;
    event_length_next   = event_length;
    silence_length_next = silence_length;
    start_flag          = 1'b0;
    end_flag            = 1'b0;
    unique case (state)
      aed_pkg::ST_SOUNDING: begin
        event_length_next = ev_inc;
        if (below) begin
          silence_length_next = '0;
          state_next          = aed_pkg::ST_TRAILING;
        end
      end
      aed_pkg::ST_TRAILING: begin
        event_length_next = ev_inc;
        if (below) begin
          silence_length_next = sil_inc;
          if (sil_ext > trail_ext) begin
            state_next        = aed_pkg::ST_WAITING;
            event_length_next = ev_trim[COUNT_BITS-1:0];
            end_flag          = (ev_trim > min_ext);
          end
        end else begin
          // level at or above threshold: back to sounding
          state_next = aed_pkg::ST_SOUNDING;
        end
      end
      default: begin
        state_next = aed_pkg::ST_WAITING;
        if (above) begin
          event_length_next = '0;
          state_next        = aed_pkg::ST_SOUNDING;
          start_flag        = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= aed_pkg::ST_WAITING;
      event_length   <= '0;
      silence_length <= '0;
    end else if (en) begin
      state          <= state_next;
      event_length   <= event_length_next;
      silence_length <= silence_length_next;
    end
  end

  assign result.event_start = start_flag;
  assign result.event_end   = end_flag;
  assign result.level       = aed_pkg::LEVEL_OUT_BITS'(level);
  assign result.phase       = phase_code(state_next);

endmodule

### rtl/core/audio_event_detector.sv
// audio_event_detector: top level. Input register, envelope smoother,
// level register, buffer-end detector and result register. Depends on
// aed_pkg, aed_smoother and aed_detector.
//
//  channel | signals                         | moves
//  --------+---------------------------------+------------------------------
//  src     | src_valid, src_stall, src_data  | one sample per transaction
//  res     | res_valid, res_stall, res_data  | one result per buffer end
//  cfg     | cfg_we, cfg_index, cfg_data     | one register write per cycle
//
// One sample per cycle, back to back, while src_stall is low; the envelope loop
// (one 16 x 32 multiply and add) is the single-cycle path that sets this rate.
// A buffer-end sample reaches the result register through input reg -> level
// reg -> result reg; plain samples yield nothing. Synchronous rst clears
// envelope, detector, counters and valid flags and loads reset values.
// res_stall holds up buffer-end samples and, through src_stall, those behind them.
module audio_event_detector #(
  parameter int COUNT_BITS = aed_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               src_valid,
  output logic                               src_stall,
  input  aed_pkg::src_item_t                 src_data,
  output logic                               res_valid,
  input  logic                               res_stall,
  output aed_pkg::res_item_t                 res_data,
  input  logic                               cfg_we,
  input  logic [aed_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [aed_pkg::CFG_BITS-1:0]       cfg_data
);

  aed_pkg::cfg_t cfg;

  // Pipeline stage 1: accepted sample
  logic               s1_valid;
  aed_pkg::src_item_t s1_item;
  // Pipeline stage 2: level captured at a buffer end
  logic                            s2_valid;
  logic [aed_pkg::SAMPLE_BITS-1:0] s2_level;

  logic                            out_free;
  logic                            s2_free;
  logic                            s1_go;
  logic                            src_take;
  logic                            det_en;
  logic [aed_pkg::SAMPLE_BITS-1:0] level_next;
  aed_pkg::res_item_t              det_result;

  // Handshake flow: each stage may refill in the cycle it empties.
  assign out_free  = !res_valid || !res_stall;
  assign s2_free   = !s2_valid || out_free;
  assign s1_go     = s1_valid && (!s1_item.buffer_end || s2_free);
  assign src_stall = s1_valid && !s1_go;
  assign src_take  = src_valid && !src_stall;
  assign det_en    = s2_valid && out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amp_threshold            <= aed_pkg::AMP_THRESHOLD_RST;
      cfg.response_factor          <= aed_pkg::RESPONSE_FACTOR_RST;
      cfg.trailing_silence_buffers <= aed_pkg::TRAILING_SILENCE_RST;
      cfg.min_event_buffers        <= aed_pkg::MIN_EVENT_RST;
    end else if (cfg_we) begin
      unique case (aed_pkg::cfg_index_t'(cfg_index))
        aed_pkg::CFG_AMP_THRESHOLD:    cfg.amp_threshold            <= cfg_data;
        aed_pkg::CFG_RESPONSE_FACTOR:  cfg.response_factor          <= cfg_data;
        aed_pkg::CFG_TRAILING_SILENCE: cfg.trailing_silence_buffers <= cfg_data;
        aed_pkg::CFG_MIN_EVENT:        cfg.min_event_buffers        <= cfg_data;
      endcase
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (src_take) begin
      s1_item <= src_data;
    end
  end

  aed_smoother u_smoother (
    .clk             (clk),
    .rst             (rst),
    .en              (s1_go),
    .sample          (s1_item.sample),
    .response_factor (cfg.response_factor),
    .level_next      (level_next)
  );

  // Stage 2: only buffer-end samples occupy it
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go && s1_item.buffer_end) begin
      s2_valid <= 1'b1;
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.buffer_end) begin
      s2_level <= level_next;
    end
  end

  aed_detector #(
    .COUNT_BITS (COUNT_BITS)
  ) u_detector (
    .clk    (clk),
    .rst    (rst),
    .en     (det_en),
    .level  (s2_level),
    .cfg    (cfg),
    .result (det_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (det_en) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (det_en) begin
      res_data <= det_result;
    end
  end

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for audio_event_detector. It holds a per-sample
// predictor of the envelope smoother and the buffer-end event detector.
// Depends on aed_pkg and the audio_event_detector RTL.
`timescale 1ns / 100ps

module tb_top;
  import aed_pkg::*;

  // Worst case: about 770 samples, each waiting out the longest send gap, the
  // longest result stall and the pipeline, plus settles and register loads.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam longint     COUNT_MAX    = 65535;
  localparam int         SETTLE_CYCLES = 8;   // pipeline: input, level and result registers

  logic clk;
  logic rst = 1'b1;

  logic      src_valid = 1'b0;
  logic      src_stall;
  src_item_t src_data  = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_data;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_AMP_THRESHOLD;
  logic [CFG_BITS-1:0]       cfg_data  = '0;

  audio_event_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Samples waiting to be sent, and detector reports still owed by the DUT.
  src_item_t pending_samples[$];
  res_item_t expected_reports[$];

  // Per-phase switches for back-to-back traffic on either side.
  bit src_burst = 1'b0;
  bit res_burst = 1'b0;

  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned samples_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned starts_seen = 0;
  int unsigned ends_seen = 0;
  int unsigned settings_loaded = 0;

  // Predictor copy of the register file, reset values from the package.
  longint thr_cfg     = AMP_THRESHOLD_RST;
  longint factor_cfg  = RESPONSE_FACTOR_RST;
  longint silence_cfg = TRAILING_SILENCE_RST;
  longint min_len_cfg = MIN_EVENT_RST;

  // Predictor state: envelope with 16 fraction bits, phase, buffer counters.
  longint                env_acc     = 0;
  logic [PHASE_BITS-1:0] det_phase   = PHASE_WAITING;
  longint                event_count = 0;
  longint                quiet_count = 0;

  // Steps the envelope for one sample; on a buffer end also steps the
  // detector and returns 1 with the report it should produce.
  function automatic bit advance_detector(input src_item_t it, output res_item_t r);
    longint mag, tgt, lvl;
    bit above, below, got_start, got_end;
    r = '0;
    mag = $signed(it.sample);
    if (mag < 0) mag = -mag;
    tgt = mag << 16;
    // step floors toward minus infinity in both directions
    if (tgt >= env_acc) env_acc = env_acc + ((factor_cfg * (tgt - env_acc)) >> 16);
    else env_acc = env_acc - ((factor_cfg * (env_acc - tgt) + 65535) >> 16);
    if (!it.buffer_end) return 1'b0;

    lvl = env_acc >> 16;
    // equal to the threshold is neither above nor below
    above = lvl > thr_cfg;
    below = lvl < thr_cfg;
    got_start = 1'b0;
    got_end = 1'b0;
    case (det_phase)
      PHASE_SOUNDING: begin
        if (event_count < COUNT_MAX) event_count++;
        if (below) begin
          quiet_count = 0;
          det_phase = PHASE_TRAILING;
        end
      end
      PHASE_TRAILING: begin
        if (event_count < COUNT_MAX) event_count++;
        if (below) begin
          if (quiet_count < COUNT_MAX) quiet_count++;
          if (quiet_count > silence_cfg) begin
            det_phase = PHASE_WAITING;
            event_count = (event_count >= silence_cfg) ? event_count - silence_cfg : 0;
            got_end = event_count > min_len_cfg;
          end
        end else begin
          det_phase = PHASE_SOUNDING;
        end
      end
      default: begin
        det_phase = PHASE_WAITING;
        if (above) begin
          event_count = 0;
          det_phase = PHASE_SOUNDING;
          got_start = 1'b1;
        end
      end
    endcase
    if (got_start) starts_seen++;
    if (got_end) ends_seen++;
    r.event_start = got_start;
    r.event_end   = got_end;
    r.level       = lvl[LEVEL_OUT_BITS-1:0];
    r.phase       = det_phase;
    return 1'b1;
  endfunction

  // Sender: predicts on every accepted transaction, then either holds the
  // stalled payload, idles out the drawn gap, or presents the next sample.
  always @(posedge clk) begin : drive_samples
    res_item_t want;
    if (rst) begin
      src_valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (src_valid && !src_stall) begin
        samples_sent++;
        if (advance_detector(src_data, want)) expected_reports.push_back(want);
      end
      if (!src_valid || !src_stall) begin
        if (gap_left != 0) begin
          src_valid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (pending_samples.size() != 0) begin
          src_data  <= pending_samples.pop_front();
          src_valid <= 1'b1;
          gap_left  <= src_burst ? 0 : $urandom_range(0, 9);
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: checks each accepted report against the oldest prediction and
  // draws a stall length before the next one.
  always @(posedge clk) begin : take_reports
    res_item_t want;
    int unsigned hold;
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (res_valid && !res_stall) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, got %h", $time, res_data);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("event_start", want.event_start, res_data.event_start);
          check_field("event_end", want.event_end, res_data.event_end);
          check_field("level", want.level, res_data.level);
          check_field("phase", want.phase, res_data.phase);
        end
        hold = res_burst ? 0 : $urandom_range(0, 9);
      end
      if (hold != 0) begin
        res_stall  <= 1'b1;
        stall_left <= hold - 1;
      end else begin
        res_stall  <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d reports outstanding", $time, expected_reports.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Writes all four registers back to back; only called while idle.
  task automatic load_settings(input int unsigned thr, input int unsigned fac,
                               input int unsigned sil, input int unsigned min_len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_AMP_THRESHOLD;
    cfg_data  <= thr[CFG_BITS-1:0];
    @(posedge clk);
    cfg_index <= CFG_RESPONSE_FACTOR;
    cfg_data  <= fac[CFG_BITS-1:0];
    @(posedge clk);
    cfg_index <= CFG_TRAILING_SILENCE;
    cfg_data  <= sil[CFG_BITS-1:0];
    @(posedge clk);
    cfg_index <= CFG_MIN_EVENT;
    cfg_data  <= min_len[CFG_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_cfg     = thr;
    factor_cfg  = fac;
    silence_cfg = sil;
    min_len_cfg = min_len;
    settings_loaded++;
  endtask

  // Stimulus waits here until all samples are sent and every owed report is
  // back, then lets plain samples still in the smoother drain out.
  task automatic settle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || src_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_sample(input int value, input bit last);
    src_item_t it;
    it.sample     = value[SAMPLE_BITS-1:0];
    it.buffer_end = last;
    pending_samples.push_back(it);
  endtask

  // Random sign on a magnitude; full scale maps to the most negative code.
  function automatic int signed_sample(input int mag);
    if (mag >= 32768) return -32768;
    if (mag < 0) return 0;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Well-formed buffers of 1..5 samples, grouped in runs of one mood so the
  // envelope really crosses the threshold and silence gets long enough to
  // close events. Noise buffers mix in random samples and stray buffer ends.
  task automatic queue_traffic(input int n);
    int left, mood, run, len, thr;
    thr = int'(thr_cfg);
    left = n;
    run = 0;
    while (left > 0) begin
      if (run == 0) begin
        mood = $urandom_range(0, 9);
        run  = $urandom_range(1, 10);
      end
      run--;
      len = $urandom_range(1, 5);
      for (int k = 0; k < len && left > 0; k++) begin
        case (mood)
          0, 1, 2: queue_sample(signed_sample($urandom_range(thr, 32768)), k == len - 1);
          3, 4, 5: queue_sample(signed_sample($urandom_range(0, thr)), k == len - 1);
          6, 7: queue_sample(signed_sample(thr + $urandom_range(0, 4) - 2), k == len - 1);
          8: queue_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 1));
          default: begin
            case ($urandom_range(0, 3))
              0: queue_sample(32767, k == len - 1);
              1: queue_sample(-32768, k == len - 1);
              2: queue_sample(0, k == len - 1);
              default: queue_sample(-1, k == len - 1);
            endcase
          end
        endcase
        left--;
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: field extremes, slow envelope, nothing should fire.
    queue_sample(32767, 1'b0);
    queue_sample(-32768, 1'b1);
    queue_sample(0, 1'b1);
    queue_sample(-1, 1'b0);
    queue_sample(1, 1'b1);
    settle();

    // Fast envelope: start, level equal to threshold while sounding, drop to
    // trailing, equal level resumes sounding, silence runs out and the end is
    // reported, then an equal level while waiting starts nothing.
    load_settings(100, 65535, 1, 0);
    queue_sample(-32768, 1'b1);
    queue_sample(100, 1'b1);
    queue_sample(0, 1'b1);
    queue_sample(101, 1'b1);
    queue_sample(0, 1'b1);
    queue_sample(0, 1'b1);
    queue_sample(0, 1'b1);
    queue_sample(101, 1'b1);
    queue_sample(32767, 1'b0);
    queue_sample(-32767, 1'b0);
    queue_sample(0, 1'b1);
    settle();

    // Event closes but is too short to be reported.
    load_settings(100, 65535, 0, 65535);
    queue_sample(-32768, 1'b1);
    queue_sample(0, 1'b1);
    queue_sample(0, 1'b1);
    settle();

    // Register extremes: frozen envelope with zero threshold, then a
    // threshold the level can never exceed.
    load_settings(0, 0, 65535, 65535);
    queue_traffic(75);
    settle();
    load_settings(32768, 65535, 0, 0);
    queue_traffic(75);
    settle();

    // Random settings, mostly fast envelopes and short silences so events
    // open and close often; some phases run without idling on one side.
    for (int p = 0; p < 8; p++) begin
      src_burst = ($urandom_range(0, 3) == 0);
      res_burst = ($urandom_range(0, 3) == 0);
      load_settings($urandom_range(20, 4000),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4000)
                                                : $urandom_range(4000, 65535),
                    $urandom_range(0, 6), $urandom_range(0, 6));
      queue_traffic(75);
      settle();
    end

    if (expected_reports.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, expected_reports.size());
      mismatch_count++;
    end
    $display("Ran %0d samples through %0d register settings, checked %0d reports",
             samples_sent, settings_loaded, reports_seen);
    $display("Saw %0d event starts and %0d event ends under random gaps and stalls",
             starts_seen, ends_seen);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
